// ----- sv/icv_pkg.sv -----
// Shared types and codes for the indexed compacting vector.
// No dependencies; used by icv_cell, indexed_compacting_vector, icv_checker and the testbench top.
package icv_pkg;

  localparam int unsigned DATA_W = 32;

  // request codes; codes above OP_COUNT behave as a count query
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_APPEND = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_POS  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // per-item update enables broadcast to every cell
  typedef struct packed {
    logic wr_en;
    logic app_en;
    logic rm_en;
  } icv_ctl_t;

endpackage

// ----- sv/icv_cell.sv -----
// One entry of the vector: holds a word, takes a write, an append or the
// word of its upper neighbour on removal. Depends on icv_pkg.
module icv_cell
  import icv_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic              clk,
  input  icv_ctl_t          ctl,
  input  logic [PW-1:0]     position,
  input  logic [CW-1:0]     count,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] up_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_term
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              pos_hit;
  logic              tail_hit;
  logic              above_pos;

  assign pos_hit   = (position == PW'(INDEX));
  assign tail_hit  = (count == CW'(INDEX));
  assign above_pos = (PW'(INDEX) >= position);

  always_comb begin
    data_nxt = data_r;
    if (ctl.wr_en && pos_hit) begin
      data_nxt = value;
    end else if (ctl.app_en && tail_hit) begin
      data_nxt = value;
    end else if (ctl.rm_en && above_pos) begin
      data_nxt = up_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_term = pos_hit ? data_r : '0;

endmodule

// ----- sv/indexed_compacting_vector.sv -----
// Indexed compacting vector: top level, count register and result stage.
// Depends on icv_pkg and icv_cell.
//
// A list of up to CAPACITY 32-bit words kept dense in a row of cells. Each
// item (read, write, append, remove, count query) is taken while start is
// high; busy stays low, so one item may be started every cycle. The result
// appears on the out_ ports for exactly one cycle, marked by out_valid, in
// the cycle after the item was taken; the receiver cannot stall it. A
// removal moves every word above the removed one down one cell at the same
// clock edge. out_count is the number of words held after the item. A read
// of an invalid position returns zero with a position status.
module indexed_compacting_vector
  import icv_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_operation,
  input  logic [$clog2(CAPACITY)-1:0]   in_position,
  input  logic [DATA_W-1:0]             in_value,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [DATA_W-1:0]             out_read_value,
  output logic [$clog2(CAPACITY+1)-1:0] out_count
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              accept;
  logic              in_range;
  logic              full;
  icv_ctl_t          ctl;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [1:0]        status_nxt;
  logic [DATA_W-1:0] rd_r;
  logic [DATA_W-1:0] rd_nxt;
  logic [DATA_W-1:0] rd_any;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign in_range = (CW'(in_position) < count_r);
  assign full     = (count_r == CW'(CAPACITY));

  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_nxt     = '0;
    case (in_operation)
      OP_READ: begin
        if (in_range) rd_nxt = rd_any;
        else          status_nxt = ST_POS;
      end
      OP_WRITE: begin
        if (in_range) ctl.wr_en = accept;
        else          status_nxt = ST_POS;
      end
      OP_APPEND: begin
        if (!full) begin
          ctl.app_en = accept;
          count_nxt  = count_r + CW'(1);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (in_range) begin
          ctl.rm_en = accept;
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = ST_POS;
        end
      end
      OP_COUNT: ;
      default: ;
    endcase
  end

  // only the addressed cell drives a non-zero term
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] up;
    if (g == CAPACITY - 1) begin : g_top
      assign up = cell_data[g];
    end else begin : g_mid
      assign up = cell_data[g+1];
    end
    icv_cell #(
      .INDEX (g),
      .PW    (PW),
      .CW    (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .position (in_position),
      .count    (count_r),
      .value    (in_value),
      .up_data  (up),
      .data     (cell_data[g]),
      .rd_term  (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rd_r;
  assign out_count      = count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("item taken without a result");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_count == CW'(CAPACITY)))
    else $error("full status with list not full");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status_nxt != ST_OK) |=> (count_r == $past(count_r)))
    else $error("failed item changed the count");
`endif

endmodule

// ----- tb/icv_checker.sv -----
// Result checker for the indexed compacting vector testbench.
// Watches the item and result ports, keeps its own copy of the list and
// compares each result with the oldest prediction. Depends on icv_pkg.
`timescale 1ns / 100ps

module icv_checker
  import icv_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    in_operation,
  input  logic [$clog2(CAPACITY)-1:0]   in_position,
  input  logic [DATA_W-1:0]             in_value,
  input  logic                          out_valid,
  input  logic [1:0]                    out_status,
  input  logic [DATA_W-1:0]             out_read_value,
  input  logic [$clog2(CAPACITY+1)-1:0] out_count,
  input  logic                          closing,
  output int                            mismatches,
  output int                            outstanding
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_value;
    logic [CW-1:0]     count;
  } outcome_t;

  logic [DATA_W-1:0] words [CAPACITY];
  logic [CW-1:0]     held;
  outcome_t          due_results [$];
  outcome_t          want;
  bit                closed;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    closed      = 1'b0;
    held        = '0;
  end

  task automatic report(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // applies one item to the local list and returns the result it gives
  function automatic outcome_t apply_request(input logic [2:0] op,
                                             input logic [$clog2(CAPACITY)-1:0] pos,
                                             input logic [DATA_W-1:0] val);
    outcome_t r;
    logic     in_range;
    r.status     = ST_OK;
    r.read_value = '0;
    in_range     = CW'(pos) < held;
    case (op)
      OP_READ: begin
        if (in_range) r.read_value = words[pos];
        else r.status = ST_POS;
      end
      OP_WRITE: begin
        if (in_range) words[pos] = val;
        else r.status = ST_POS;
      end
      OP_APPEND: begin
        if (held < CAPACITY) begin
          words[held] = val;
          held++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (in_range) begin
          // later entries close the gap
          for (int i = int'(pos); i + 1 < int'(held); i++) words[i] = words[i + 1];
          held--;
        end else begin
          r.status = ST_POS;
        end
      end
      default: ;
    endcase
    r.count = held;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held = '0;
      foreach (words[i]) words[i] = '0;
      due_results.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (due_results.size() == 0) begin
          report("result with no item outstanding");
        end else begin
          want = due_results.pop_front();
          if (out_status !== want.status)
            report($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_read_value !== want.read_value)
            report($sformatf("read_value %h, expected %h", out_read_value, want.read_value));
          if (out_count !== want.count)
            report($sformatf("count %0d, expected %0d", out_count, want.count));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        due_results.push_back(apply_request(in_operation, in_position, in_value));
      if (closing && !closed) begin
        closed = 1'b1;
        if (due_results.size() != 0)
          report($sformatf("%0d results never arrived", due_results.size()));
      end
    end
    outstanding = due_results.size();
  end

endmodule

// ----- tb/indexed_compacting_vector_tb.sv -----
// Top of the indexed compacting vector testbench: clock, reset, stimulus
// and verdict. Depends on icv_pkg, indexed_compacting_vector, icv_checker.
`timescale 1ns / 100ps

module indexed_compacting_vector_tb;
  import icv_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RANDOM_ITEMS = 800;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_operation;
  logic [PW-1:0]     in_position;
  logic [DATA_W-1:0] in_value;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_read_value;
  logic [CW-1:0]     out_count;
  logic              closing;
  int                mismatches;
  int                outstanding;

  // rough fill level, used to aim positions at live entries and to steer the fill bias
  int                level;

  indexed_compacting_vector #(.CAPACITY(CAPACITY)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_read_value(out_read_value),
    .out_count     (out_count)
  );

  icv_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_read_value(out_read_value),
    .out_count     (out_count),
    .closing       (closing),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[indexed_compacting_vector] ERROR");
    $finish;
  end

  // present one item and hold it until taken
  task automatic send(input logic [2:0] op, input logic [PW-1:0] pos,
                      input logic [DATA_W-1:0] val);
    start        <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == OP_APPEND && level < CAPACITY) level++;
    if (op == OP_REMOVE && int'(pos) < level) level--;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic random_item(input int fill_bias);
    int            r;
    int            app_w;
    logic [2:0]    op;
    logic [PW-1:0] pos;
    app_w = fill_bias > 0 ? 45 : (fill_bias < 0 ? 10 : 28);
    r = $urandom_range(0, 99);
    if (r < app_w) op = OP_APPEND;
    else if (r < 55) op = OP_REMOVE;
    else if (r < 75) op = OP_READ;
    else if (r < 92) op = OP_WRITE;
    else if (r < 97) op = OP_COUNT;
    else op = OP_COUNT + 3'($urandom_range(1, 3));
    if (level > 0 && $urandom_range(0, 99) < 85) pos = PW'($urandom_range(0, level - 1));
    else pos = PW'($urandom_range(0, CAPACITY - 1));
    send(op, pos, $urandom);
  endtask

  initial begin
    int sent;
    int burst;
    int bias;
    bit held_off;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_COUNT;
    in_position  = '0;
    in_value     = '0;
    closing      = 1'b0;
    level        = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: count query and position errors
    send(OP_COUNT, '0, '0);
    send(OP_READ, '0, '1);
    send(OP_WRITE, '1, '0);
    send(OP_REMOVE, '0, '0);
    // fill to capacity with extreme words
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 4)
        0: send(OP_APPEND, PW'(i), '0);
        1: send(OP_APPEND, PW'(i), '1);
        2: send(OP_APPEND, PW'(i), 32'h5555_5555);
        default: send(OP_APPEND, PW'(i), 32'hAAAA_AAAA);
      endcase
    end
    send(OP_APPEND, '0, 32'h1234_5678);  // full
    send(OP_READ, '1, '0);
    send(OP_WRITE, '1, 32'hFFFF_FFFF);
    send(OP_READ, '1, '0);
    send(OP_REMOVE, '1, '0);             // last entry
    send(OP_REMOVE, '0, '0);             // first entry, everything shifts
    send(OP_READ, PW'(CAPACITY - 2), '0);  // now beyond the count
    for (int k = 1; k <= 3; k++) send(OP_COUNT + 3'(k), '1, '1);
    pause(3);

    sent     = 0;
    held_off = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      bias  = $urandom_range(0, 2) - 1;
      if (level >= CAPACITY - 1) bias = -1;
      if (level <= 1) bias = 1;
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        random_item(bias);
        sent++;
      end
      if (!held_off && sent >= RANDOM_ITEMS / 2) begin
        held_off = 1'b1;
        wait_drained();
      end else if ($urandom_range(0, 3) != 0) begin
        pause($urandom_range(1, 7));
      end
    end

    wait_drained();
    repeat (3) @(posedge clk);
    closing <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("[indexed_compacting_vector] OK");
    end else begin
      $display("[indexed_compacting_vector] ERROR");
    end
    $finish;
  end

endmodule
